// File: design/npe_pkg.sv
package npe_pkg;

    // store depth and derived widths
    localparam int SIZE   = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int CNT_W  = $clog2(SIZE + 1);

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN_RD,
        S_SCAN_FIRST,
        S_SCAN,
        S_FIND,
        S_SWAP,
        S_REV,
        S_REV_HI,
        S_REV_WLO,
        S_REV_WHI,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    // operand selection of the shared comparator
    typedef enum logic {
        CMP_SCAN,
        CMP_FIND
    } cmp_sel_t;

    typedef struct packed {
        cmp_sel_t sel;
        elem_t    cur;
        elem_t    prev;
        elem_t    pivot;
    } cmp_req_t;

endpackage

// File: design/npe_if.sv
// element channel into the engine
interface npe_seq_if;
    logic           valid;
    logic           ready;
    npe_pkg::elem_t element;
    logic           final_element;

    modport source (output valid, output element, output final_element, input ready);
    modport sink   (input valid, input element, input final_element, output ready);
endinterface

// permutation channel out of the engine
interface npe_perm_if;
    logic           valid;
    logic           ready;
    npe_pkg::elem_t permuted_value;
    logic           end_of_run;
    logic           wrapped;
    logic           truncated;

    modport source (output valid, output permuted_value, output end_of_run,
                    output wrapped, output truncated, input ready);
    modport sink   (input valid, input permuted_value, input end_of_run,
                    input wrapped, input truncated, output ready);
endinterface

// File: design/next_permutation_engine.sv
// next_permutation_engine: rewrites a loaded sequence into its next
// lexicographic permutation and streams it back out.
// The seq channel takes one element per item, one item per cycle while
// loading; final_element closes the sequence. Up to SIZE elements are stored,
// later ones are dropped and the run is marked truncated.
// After the final item the sequencer walks the element RAM with one shared
// signed comparator: the ascent scan, the search for the swap partner (its
// hit writes the partner into the pivot slot), the swap and the suffix
// reversal one exchanged pair at a time, all bound by the RAM's one read
// port and one write port.
// The perm channel then gives n items, each read from RAM ahead of the output
// register; end_of_run marks the last, wrapped and truncated hold on
// every item of the run. A greatest permutation is reversed and wrapped.
// seq.ready is low from the final item until the last result sits in the
// output register; the next sequence may load while that result waits.
// A stalled receiver freezes emission; no result is lost or repeated.
// Reset (rst_n low, asynchronous) empties the store and drops any pending
// result; the RAM contents are not cleared and need no clearing.
module next_permutation_engine (
    input  logic              clk,
    input  logic              rst_n,
    npe_seq_if.sink           seq,
    npe_perm_if.source        perm
);

    npe_pkg::state_t state_reg, state_next;
    npe_pkg::cnt_t   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            wrap_reg, wrap_next;
    npe_pkg::idx_t   last_reg, last_next;
    npe_pkg::idx_t   lo_reg, lo_next;
    npe_pkg::idx_t   hi_reg, hi_next;
    npe_pkg::idx_t   piv_reg, piv_next;
    npe_pkg::elem_t  prev_reg, prev_next;
    npe_pkg::elem_t  pval_reg, pval_next;

    logic            out_valid_reg, out_valid_next;
    npe_pkg::elem_t  out_value_reg, out_value_next;
    logic            out_end_reg, out_end_next;
    logic            out_wrap_reg, out_wrap_next;
    logic            out_trunc_reg, out_trunc_next;

    logic            ram_we;
    npe_pkg::idx_t   ram_waddr;
    npe_pkg::elem_t  ram_wdata;
    logic            ram_re;
    npe_pkg::idx_t   ram_raddr;
    npe_pkg::elem_t  ram_rdata;

    npe_pkg::cmp_req_t cmp_req;
    logic              cmp_gt;

    logic            seq_take;
    logic            out_free;
    npe_pkg::cnt_t   fill_next;
    npe_pkg::cnt_t   fill_minus1;

    // element store
    npe_ram #(
        .WIDTH (npe_pkg::DATA_W),
        .DEPTH (npe_pkg::SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared comparator
    npe_cmp u_cmp (
        .req (cmp_req),
        .gt  (cmp_gt)
    );

    // channel handshakes
    assign seq.ready = (state_reg == npe_pkg::S_LOAD);
    assign seq_take  = seq.valid && seq.ready;
    assign out_free  = !out_valid_reg || perm.ready;

    assign perm.valid          = out_valid_reg;
    assign perm.permuted_value = out_value_reg;
    assign perm.end_of_run     = out_end_reg;
    assign perm.wrapped        = out_wrap_reg;
    assign perm.truncated      = out_trunc_reg;

    // fill level after a load item
    assign fill_next   = (count_reg < npe_pkg::CNT_W'(npe_pkg::SIZE))
                         ? count_reg + npe_pkg::CNT_W'(1) : count_reg;
    assign fill_minus1 = fill_next - npe_pkg::CNT_W'(1);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npe_pkg::S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        wrap_reg      <= wrap_next;
        last_reg      <= last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        piv_reg       <= piv_next;
        prev_reg      <= prev_next;
        pval_reg      <= pval_next;
        out_value_reg <= out_value_next;
        out_end_reg   <= out_end_next;
        out_wrap_reg  <= out_wrap_next;
        out_trunc_reg <= out_trunc_next;
    end

    // sequencer: next state, RAM port and comparator control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        wrap_next      = wrap_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        piv_next       = piv_reg;
        prev_next      = prev_reg;
        pval_next      = pval_reg;
        out_valid_next = out_valid_reg && !perm.ready;
        out_value_next = out_value_reg;
        out_end_next   = out_end_reg;
        out_wrap_next  = out_wrap_reg;
        out_trunc_next = out_trunc_reg;

        ram_we    = 1'b0;
        ram_waddr = lo_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = lo_reg;

        cmp_req.sel   = npe_pkg::CMP_SCAN;
        cmp_req.cur   = ram_rdata;
        cmp_req.prev  = prev_reg;
        cmp_req.pivot = pval_reg;

        unique case (state_reg)
            npe_pkg::S_LOAD:
            begin
                if (seq_take)
                begin
                    // store while room is left, otherwise note the drop
                    if (count_reg < npe_pkg::CNT_W'(npe_pkg::SIZE))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = count_reg[npe_pkg::IDX_W-1:0];
                        ram_wdata = seq.element;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = fill_next;
                    if (seq.final_element)
                    begin
                        last_next  = fill_minus1[npe_pkg::IDX_W-1:0];
                        wrap_next  = 1'b0;
                        state_next = npe_pkg::S_SCAN_RD;
                    end
                end
            end

            npe_pkg::S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = last_reg;
                lo_next    = last_reg;
                state_next = npe_pkg::S_SCAN_FIRST;
            end

            npe_pkg::S_SCAN_FIRST:
            begin
                // single element: nothing to compare, reverse is a no-op
                if (lo_reg == '0)
                begin
                    wrap_next  = 1'b1;
                    hi_next    = last_reg;
                    state_next = npe_pkg::S_REV;
                end
                else
                begin
                    prev_next  = ram_rdata;
                    ram_re     = 1'b1;
                    ram_raddr  = lo_reg - npe_pkg::IDX_W'(1);
                    lo_next    = lo_reg - npe_pkg::IDX_W'(1);
                    state_next = npe_pkg::S_SCAN;
                end
            end

            npe_pkg::S_SCAN:
            begin
                // rightmost strict ascent: a[lo+1] > a[lo]
                cmp_req.sel = npe_pkg::CMP_SCAN;
                if (cmp_gt)
                begin
                    piv_next   = lo_reg;
                    pval_next  = ram_rdata;
                    ram_re     = 1'b1;
                    ram_raddr  = last_reg;
                    hi_next    = last_reg;
                    state_next = npe_pkg::S_FIND;
                end
                else if (lo_reg == '0)
                begin
                    wrap_next  = 1'b1;
                    hi_next    = last_reg;
                    state_next = npe_pkg::S_REV;
                end
                else
                begin
                    prev_next  = ram_rdata;
                    ram_re     = 1'b1;
                    ram_raddr  = lo_reg - npe_pkg::IDX_W'(1);
                    lo_next    = lo_reg - npe_pkg::IDX_W'(1);
                end
            end

            npe_pkg::S_FIND:
            begin
                // rightmost element strictly above the pivot
                cmp_req.sel = npe_pkg::CMP_FIND;
                if (cmp_gt)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = piv_reg;
                    ram_wdata  = ram_rdata;
                    state_next = npe_pkg::S_SWAP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = hi_reg - npe_pkg::IDX_W'(1);
                    hi_next    = hi_reg - npe_pkg::IDX_W'(1);
                end
            end

            npe_pkg::S_SWAP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = pval_reg;
                lo_next    = piv_reg + npe_pkg::IDX_W'(1);
                hi_next    = last_reg;
                state_next = npe_pkg::S_REV;
            end

            npe_pkg::S_REV:
            begin
                // reverse lo..hi one pair at a time
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lo_reg;
                    state_next = npe_pkg::S_REV_HI;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = npe_pkg::S_EMIT_RD;
                end
            end

            npe_pkg::S_REV_HI:
            begin
                prev_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = hi_reg;
                state_next = npe_pkg::S_REV_WLO;
            end

            npe_pkg::S_REV_WLO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata;
                state_next = npe_pkg::S_REV_WHI;
            end

            npe_pkg::S_REV_WHI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = prev_reg;
                lo_next    = lo_reg + npe_pkg::IDX_W'(1);
                hi_next    = hi_reg - npe_pkg::IDX_W'(1);
                state_next = npe_pkg::S_REV;
            end

            npe_pkg::S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = lo_reg;
                state_next = npe_pkg::S_EMIT_LD;
            end

            npe_pkg::S_EMIT_LD:
            begin
                // read data holds until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = ram_rdata;
                    out_end_next   = (lo_reg == last_reg);
                    out_wrap_next  = wrap_reg;
                    out_trunc_next = ovf_reg;
                    if (lo_reg == last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = npe_pkg::S_LOAD;
                    end
                    else
                    begin
                        lo_next    = lo_reg + npe_pkg::IDX_W'(1);
                        state_next = npe_pkg::S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = npe_pkg::S_LOAD;
            end
        endcase
    end

    // the partner search never runs into the pivot or below it
    a_find_above_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == npe_pkg::S_FIND) |-> (hi_reg > piv_reg))
        else $error("partner search passed the pivot");

    // a reversal exchange only happens on an open range
    a_rev_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == npe_pkg::S_REV_HI) |=> (lo_reg < hi_reg))
        else $error("reversal exchange on a closed range");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= npe_pkg::CNT_W'(npe_pkg::SIZE))
        else $error("fill count beyond store depth");

    // loading the last result of a run reopens the store empty
    a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == npe_pkg::S_EMIT_LD) && out_free && (lo_reg == last_reg))
        |=> ((state_reg == npe_pkg::S_LOAD) && (count_reg == '0) && !ovf_reg
             && perm.valid && perm.end_of_run))
        else $error("run did not close cleanly");

endmodule

// File: design/npe_ram.sv
module npe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/npe_cmp.sv
module npe_cmp (
    input  npe_pkg::cmp_req_t req,
    output logic              gt
);

    npe_pkg::elem_t lhs;
    npe_pkg::elem_t rhs;

    // operand steering: scan tests for an ascent, find tests against the pivot
    always_comb
    begin
        case (req.sel)
            npe_pkg::CMP_SCAN:
            begin
                lhs = req.prev;
                rhs = req.cur;
            end
            default:
            begin
                lhs = req.cur;
                rhs = req.pivot;
            end
        endcase
    end

    // signed strict greater-than
    assign gt = (lhs > rhs);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // longest run of cycles without any accepted item before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles to keep watching for stray results once nothing is expected
    localparam int DRAIN_CYCLES   = 150;

    localparam npe_pkg::elem_t ELEM_MIN = {1'b1, {(npe_pkg::DATA_W-1){1'b0}}};
    localparam npe_pkg::elem_t ELEM_MAX = {1'b0, {(npe_pkg::DATA_W-1){1'b1}}};

    typedef struct packed {
        npe_pkg::elem_t value;
        logic           last;
        logic           wrap;
        logic           trunc;
    } perm_result_t;

    logic clk = 1'b0;
    logic rst_n;

    npe_seq_if  seq_ch ();
    npe_perm_if perm_ch ();

    next_permutation_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .seq   (seq_ch),
        .perm  (perm_ch)
    );

    // predictor state: the sequence being loaded
    npe_pkg::elem_t held_seq [npe_pkg::SIZE];
    int    held_count = 0;
    logic  dropped_any = 1'b0;

    perm_result_t expected_perm_q [$];

    int error_count  = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string field,
                                   input logic [npe_pkg::DATA_W-1:0] got,
                                   input logic [npe_pkg::DATA_W-1:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // store one element; on the final item compute the next permutation
    function automatic void take_element(input npe_pkg::elem_t value, input logic last);
        int             n;
        int             pivot;
        int             lo;
        int             hi;
        npe_pkg::elem_t tmp;
        logic           wrap;
        perm_result_t   res;

        if (held_count < npe_pkg::SIZE)
        begin
            held_seq[held_count] = value;
            held_count++;
        end
        else
        begin
            dropped_any = 1'b1;
        end
        if (!last)
            return;

        n = held_count;
        pivot = 0;
        // rightmost strict ascent
        for (int i = n - 1; i >= 1; i--)
        begin
            if (held_seq[i] > held_seq[i-1])
            begin
                pivot = i;
                break;
            end
        end
        wrap = (pivot == 0);

        // swap pivot with the rightmost strictly greater element
        if (!wrap)
        begin
            for (int j = n - 1; j >= pivot; j--)
            begin
                if (held_seq[j] > held_seq[pivot-1])
                begin
                    tmp = held_seq[j];
                    held_seq[j] = held_seq[pivot-1];
                    held_seq[pivot-1] = tmp;
                    break;
                end
            end
        end

        // reverse the suffix, or everything on wrap
        lo = pivot;
        hi = n - 1;
        while (lo < hi)
        begin
            tmp = held_seq[lo];
            held_seq[lo] = held_seq[hi];
            held_seq[hi] = tmp;
            lo++;
            hi--;
        end

        for (int k = 0; k < n; k++)
        begin
            res.value = held_seq[k];
            res.last  = (k == n - 1);
            res.wrap  = wrap;
            res.trunc = dropped_any;
            expected_perm_q.push_back(res);
        end
        held_count = 0;
        dropped_any = 1'b0;
    endfunction

    // offer one item, idling first at random, and predict once accepted
    task automatic send_element(input npe_pkg::elem_t value, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            seq_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seq_ch.valid         <= 1'b1;
        seq_ch.element       <= value;
        seq_ch.final_element <= last;
        @(posedge clk);
        while (!seq_ch.ready)
            @(posedge clk);
        take_element(value, last);
    endtask

    task automatic send_run(input npe_pkg::elem_t vals [$]);
        for (int k = 0; k < vals.size(); k++)
            send_element(vals[k], k == vals.size() - 1);
    endtask

    // stop offering items and wait for every predicted result
    task automatic wait_drain();
        seq_ch.valid <= 1'b0;
        while (expected_perm_q.size() != 0)
            @(posedge clk);
    endtask

    // a lone element has no ascent and wraps
    task automatic test_single_element();
        npe_pkg::elem_t vals [$];

        vals = '{npe_pkg::elem_t'(32'h1234_5678)};
        send_run(vals);
        wait_drain();
    endtask

    // equal elements never form a strict ascent
    task automatic test_equal_elements();
        npe_pkg::elem_t vals [$];

        vals = '{npe_pkg::elem_t'(5), npe_pkg::elem_t'(5), npe_pkg::elem_t'(5)};
        send_run(vals);
        wait_drain();
    endtask

    // descending extremes: greatest permutation, reversed whole
    task automatic test_greatest_permutation();
        npe_pkg::elem_t vals [$];

        vals = '{ELEM_MAX, npe_pkg::elem_t'(0), ELEM_MIN};
        send_run(vals);
        wait_drain();
    endtask

    // ascent at the front; swap partner must be strictly greater
    task automatic test_extreme_ascent();
        npe_pkg::elem_t vals [$];

        vals = '{ELEM_MIN, ELEM_MAX, ELEM_MIN};
        send_run(vals);
        wait_drain();
    endtask

    // one element past the store, the final item itself dropped
    task automatic test_truncation();
        npe_pkg::elem_t vals [$];

        for (int k = 0; k <= npe_pkg::SIZE; k++)
            vals.push_back(npe_pkg::elem_t'($urandom));
        send_run(vals);
        wait_drain();
    endtask

    // random sequences of mixed length and value shape
    task automatic test_random_runs(input int src_pct, input int sink_pct, input int items);
        npe_pkg::elem_t vals [$];
        int    sent;
        int    len;
        int    shape;
        int    pick;

        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(6, 1);
            else if (pick < 92)
                len = $urandom_range(npe_pkg::SIZE, 7);
            else
                len = $urandom_range(npe_pkg::SIZE + 4, npe_pkg::SIZE + 1);
            shape = $urandom_range(3);
            vals.delete();
            for (int k = 0; k < len; k++)
            begin
                case (shape)
                    0: vals.push_back(npe_pkg::elem_t'($urandom));
                    1: vals.push_back(npe_pkg::elem_t'($urandom_range(4))
                                      - npe_pkg::elem_t'(2));
                    2:
                    begin
                        case ($urandom_range(4))
                            0: vals.push_back(ELEM_MIN);
                            1: vals.push_back(ELEM_MAX);
                            2: vals.push_back(npe_pkg::elem_t'(-1));
                            3: vals.push_back(npe_pkg::elem_t'(0));
                            default: vals.push_back(npe_pkg::elem_t'(1));
                        endcase
                    end
                    default: vals.push_back(npe_pkg::elem_t'($urandom));
                endcase
            end
            // sorted descending gives the greatest permutation
            if (shape == 3)
                vals.rsort();
            send_run(vals);
            sent += len;
        end
        wait_drain();
    endtask

    // result checker and receiver stalls
    initial
    begin
        perm_result_t want;

        perm_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && perm_ch.valid && perm_ch.ready)
            begin
                if (expected_perm_q.size() == 0)
                begin
                    report_mismatch("unexpected result", perm_ch.permuted_value, '0);
                end
                else
                begin
                    want = expected_perm_q.pop_front();
                    if (perm_ch.permuted_value !== want.value)
                        report_mismatch("permuted_value", perm_ch.permuted_value, want.value);
                    if (perm_ch.end_of_run !== want.last)
                        report_mismatch("end_of_run",
                                        npe_pkg::DATA_W'(perm_ch.end_of_run),
                                        npe_pkg::DATA_W'(want.last));
                    if (perm_ch.wrapped !== want.wrap)
                        report_mismatch("wrapped",
                                        npe_pkg::DATA_W'(perm_ch.wrapped),
                                        npe_pkg::DATA_W'(want.wrap));
                    if (perm_ch.truncated !== want.trunc)
                        report_mismatch("truncated",
                                        npe_pkg::DATA_W'(perm_ch.truncated),
                                        npe_pkg::DATA_W'(want.trunc));
                end
            end
            perm_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles with no accepted item on either channel
    always @(posedge clk)
    begin
        if ((seq_ch.valid && seq_ch.ready) || (perm_ch.valid && perm_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        seq_ch.valid = 1'b0;
        seq_ch.element = '0;
        seq_ch.final_element = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element();
        test_equal_elements();
        test_greatest_permutation();
        test_extreme_ascent();
        test_truncation();

        // idling phases: none, sender, receiver, both
        test_random_runs(0, 0, 58);
        test_random_runs(81, 0, 58);
        test_random_runs(0, 81, 58);
        test_random_runs(37, 37, 58);

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
